### hw/rtl/alcp_pkg.sv
// Shared constants and types for the active lane consolidation permute block.
package alcp_pkg;

    // Number of lanes in one vector.
    localparam int LANES = 4;

    // Width of a lane index and of an active lane count (0 to LANES).
    localparam int IDX_W = $clog2(LANES);
    localparam int CNT_W = $clog2(LANES + 1);

    typedef logic [IDX_W-1:0] lane_idx_t;
    typedef logic [CNT_W-1:0] lane_cnt_t;
    typedef logic [LANES-1:0] lane_mask_t;

endpackage

### hw/rtl/alcp_compact.sv
// One compaction lane unit: packs the selected lanes of a vector to the low end.
module alcp_compact #(
    parameter int LANE_WIDTH = 32
) (
    input  logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] src,
    input  alcp_pkg::lane_mask_t                       sel,
    output logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] dst,
    output alcp_pkg::lane_cnt_t                        count
);
    import alcp_pkg::*;

    lane_cnt_t pos [LANES];

    // Destination slot of each lane is the number of selected lanes below it.
    always_comb
    begin
        lane_cnt_t run;
        run = '0;
        for (int i = 0; i < LANES; i++)
        begin
            pos[i] = run;
            run    = run + lane_cnt_t'(sel[i]);
        end
        count = run;
    end

    // Each output slot picks the selected lane that lands on it; unfilled slots are zero.
    always_comb
    begin
        dst = '0;
        for (int k = 0; k < LANES; k++)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (sel[i] && (pos[i] == lane_cnt_t'(k)))
                begin
                    dst[k] = src[i];
                end
            end
        end
    end

endmodule

### hw/rtl/alcp_merge.sv
// Merging stage: joins the compacted vectors into the packed and rest results.
module alcp_merge #(
    parameter int LANE_WIDTH = 32
) (
    input  logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] act_first,
    input  logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] act_second,
    input  logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] ina_first,
    input  logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] ina_second,
    input  alcp_pkg::lane_cnt_t                        n_first,
    input  alcp_pkg::lane_cnt_t                        n_second,
    output logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] packed_vec,
    output logic [alcp_pkg::LANES-1:0][LANE_WIDTH-1:0] rest_vec
);
    import alcp_pkg::*;

    logic [LANES-1:0][LANE_WIDTH-1:0] helper;
    lane_cnt_t                        keep;

    // Low lanes of rest come from the inactive lanes of the first vector.
    assign keep = lane_cnt_t'(LANES) - n_first;

    // Per output lane: choose the low source or the shifted high source.
    always_comb
    begin
        lane_cnt_t off_p;
        lane_cnt_t off_h;
        for (int i = 0; i < LANES; i++)
        begin
            off_p = lane_cnt_t'(i) - n_first;
            off_h = lane_cnt_t'(i) - n_second;
            packed_vec[i] = (lane_cnt_t'(i) < n_first)
                          ? act_first[i] : act_second[off_p[IDX_W-1:0]];
            helper[i]     = (lane_cnt_t'(i) < n_second)
                          ? act_second[i] : ina_second[off_h[IDX_W-1:0]];
            rest_vec[i]   = (lane_cnt_t'(i) < keep) ? ina_first[i] : helper[i];
        end
    end

endmodule

### hw/rtl/active_lane_consolidation_permute_core.sv
// Top level of the active lane consolidation permute block.
//
// Usage: drive the two four-lane vectors and their active lane masks and
// raise start for one cycle per item. The block is never busy, so an item
// is accepted at every rising edge at which start is high; items may follow
// each other in consecutive cycles, one item per cycle sustained.
// Four compaction units work side by side (active and inactive lanes of
// each vector) and a merging stage forms both result vectors in the same
// cycle. The result is registered: done pulses high for exactly one cycle,
// the cycle after the item was accepted, with packed_lane* and rest_lane*
// valid in that cycle. No state is kept between items. Reset clears the
// done strobe; the result registers are not reset and hold stale data
// while done is low. The receiver cannot stall, so each result must be
// taken in its done cycle.
module active_lane_consolidation_permute_core #(
    parameter int LANE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [LANE_WIDTH-1:0]    first_lane0,
    input  logic signed [LANE_WIDTH-1:0]    first_lane1,
    input  logic signed [LANE_WIDTH-1:0]    first_lane2,
    input  logic signed [LANE_WIDTH-1:0]    first_lane3,
    input  logic signed [LANE_WIDTH-1:0]    second_lane0,
    input  logic signed [LANE_WIDTH-1:0]    second_lane1,
    input  logic signed [LANE_WIDTH-1:0]    second_lane2,
    input  logic signed [LANE_WIDTH-1:0]    second_lane3,
    input  alcp_pkg::lane_mask_t            first_mask,
    input  alcp_pkg::lane_mask_t            second_mask,
    output logic                            done,
    output logic signed [LANE_WIDTH-1:0]    packed_lane0,
    output logic signed [LANE_WIDTH-1:0]    packed_lane1,
    output logic signed [LANE_WIDTH-1:0]    packed_lane2,
    output logic signed [LANE_WIDTH-1:0]    packed_lane3,
    output logic signed [LANE_WIDTH-1:0]    rest_lane0,
    output logic signed [LANE_WIDTH-1:0]    rest_lane1,
    output logic signed [LANE_WIDTH-1:0]    rest_lane2,
    output logic signed [LANE_WIDTH-1:0]    rest_lane3
);
    import alcp_pkg::*;

    logic [LANES-1:0][LANE_WIDTH-1:0] vec_first;
    logic [LANES-1:0][LANE_WIDTH-1:0] vec_second;
    logic [LANES-1:0][LANE_WIDTH-1:0] act_first;
    logic [LANES-1:0][LANE_WIDTH-1:0] act_second;
    logic [LANES-1:0][LANE_WIDTH-1:0] ina_first;
    logic [LANES-1:0][LANE_WIDTH-1:0] ina_second;
    logic [LANES-1:0][LANE_WIDTH-1:0] packed_next;
    logic [LANES-1:0][LANE_WIDTH-1:0] rest_next;
    logic [LANES-1:0][LANE_WIDTH-1:0] packed_reg;
    logic [LANES-1:0][LANE_WIDTH-1:0] rest_reg;
    lane_cnt_t                        n_first;
    lane_cnt_t                        n_second;
    logic                             done_reg;
    logic                             done_next;

    // The block takes a new item every cycle.
    assign busy = 1'b0;

    // Gather the lane ports into vectors.
    assign vec_first  = {first_lane3, first_lane2, first_lane1, first_lane0};
    assign vec_second = {second_lane3, second_lane2, second_lane1, second_lane0};

    // Compaction units for active and inactive lanes of both vectors.
    alcp_compact #(.LANE_WIDTH(LANE_WIDTH)) u_act_first (
        .src   (vec_first),
        .sel   (first_mask),
        .dst   (act_first),
        .count (n_first)
    );

    alcp_compact #(.LANE_WIDTH(LANE_WIDTH)) u_act_second (
        .src   (vec_second),
        .sel   (second_mask),
        .dst   (act_second),
        .count (n_second)
    );

    alcp_compact #(.LANE_WIDTH(LANE_WIDTH)) u_ina_first (
        .src   (vec_first),
        .sel   (~first_mask),
        .dst   (ina_first),
        .count ()
    );

    alcp_compact #(.LANE_WIDTH(LANE_WIDTH)) u_ina_second (
        .src   (vec_second),
        .sel   (~second_mask),
        .dst   (ina_second),
        .count ()
    );

    // Merge the compacted vectors into the two results.
    alcp_merge #(.LANE_WIDTH(LANE_WIDTH)) u_merge (
        .act_first  (act_first),
        .act_second (act_second),
        .ina_first  (ina_first),
        .ina_second (ina_second),
        .n_first    (n_first),
        .n_second   (n_second),
        .packed_vec (packed_next),
        .rest_vec   (rest_next)
    );

    assign done_next = start;

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Result registers, loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            packed_reg <= packed_next;
            rest_reg   <= rest_next;
        end
    end

    assign done         = done_reg;
    assign packed_lane0 = packed_reg[0];
    assign packed_lane1 = packed_reg[1];
    assign packed_lane2 = packed_reg[2];
    assign packed_lane3 = packed_reg[3];
    assign rest_lane0   = rest_reg[0];
    assign rest_lane1   = rest_reg[1];
    assign rest_lane2   = rest_reg[2];
    assign rest_lane3   = rest_reg[3];

endmodule

### verif/tb_active_lane_consolidation_permute_core.sv
// Self-checking testbench for the active lane consolidation permute core.
module tb_active_lane_consolidation_permute_core;

    timeunit 1ns;
    timeprecision 1ps;

    import alcp_pkg::*;

    localparam int LW          = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 150;
    localparam int SHOW_LIMIT  = 10;

    typedef logic [LANES-1:0][LW-1:0] lane_vec_t;

    // One input item: two vectors and their active lane masks.
    typedef struct packed {
        lane_vec_t  first_v;
        lane_vec_t  second_v;
        lane_mask_t first_m;
        lane_mask_t second_m;
    } vec_pair_t;

    // One result item: the consolidated vector and the remaining lanes vector.
    typedef struct packed {
        lane_vec_t packed_v;
        lane_vec_t rest_v;
    } perm_result_t;

    // Mask pairs for the directed part, first mask in the high nibble.
    localparam logic [7:0] DIR_MASKS [18] = '{
        8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h18, 8'h81, 8'h5A, 8'hA5, 8'h3C,
        8'hC3, 8'h69, 8'h96, 8'hE7, 8'h7E, 8'h24, 8'h42, 8'h1F, 8'hF1
    };

    // Holds the permutations still owed by the core and checks each result.
    class lane_perm_scoreboard;
        perm_result_t owed_q[$];
        int errors = 0;
        int shown = 0;

        // Pack the lanes selected by the mask to the low end, zero above.
        function lane_vec_t compact(lane_vec_t v, lane_mask_t m);
            lane_vec_t r;
            int n;
            r = '0;
            n = 0;
            for (int i = 0; i < LANES; i++) begin
                if (m[i]) begin
                    r[n] = v[i];
                    n++;
                end
            end
            return r;
        endfunction

        function perm_result_t permute(vec_pair_t it);
            lane_vec_t act_first, act_second, idle_first, idle_second, helper;
            perm_result_t r;
            int nf, ns;
            act_first   = compact(it.first_v, it.first_m);
            act_second  = compact(it.second_v, it.second_m);
            idle_first  = compact(it.first_v, ~it.first_m);
            idle_second = compact(it.second_v, ~it.second_m);
            nf = $countones(it.first_m);
            ns = $countones(it.second_m);
            for (int i = 0; i < LANES; i++) begin
                r.packed_v[i] = (i < nf) ? act_first[i] : act_second[i - nf];
                helper[i]     = (i < ns) ? act_second[i] : idle_second[i - ns];
            end
            for (int i = 0; i < LANES; i++)
                r.rest_v[i] = (i < LANES - nf) ? idle_first[i] : helper[i];
            return r;
        endfunction

        function void note_item(vec_pair_t it);
            owed_q.push_back(permute(it));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void check_result(perm_result_t act);
            perm_result_t exp_r;
            bit bad;
            if (owed_q.size() == 0) begin
                errors++;
                if (shown < SHOW_LIMIT)
                    $display("ERROR: result with nothing owed: packed %h rest %h",
                             act.packed_v, act.rest_v);
                shown++;
                return;
            end
            exp_r = owed_q.pop_front();
            bad = 1'b0;
            for (int i = 0; i < LANES; i++) begin
                if (act.packed_v[i] !== exp_r.packed_v[i]) begin
                    bad = 1'b1;
                    if (shown < SHOW_LIMIT)
                        $display("ERROR: packed_lane%0d expected %h actual %h",
                                 i, exp_r.packed_v[i], act.packed_v[i]);
                end
                if (act.rest_v[i] !== exp_r.rest_v[i]) begin
                    bad = 1'b1;
                    if (shown < SHOW_LIMIT)
                        $display("ERROR: rest_lane%0d expected %h actual %h",
                                 i, exp_r.rest_v[i], act.rest_v[i]);
                end
            end
            if (bad) begin
                errors++;
                shown++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic signed [LW-1:0] first_lane0 = '0, first_lane1 = '0;
    logic signed [LW-1:0] first_lane2 = '0, first_lane3 = '0;
    logic signed [LW-1:0] second_lane0 = '0, second_lane1 = '0;
    logic signed [LW-1:0] second_lane2 = '0, second_lane3 = '0;
    lane_mask_t first_mask = '0;
    lane_mask_t second_mask = '0;
    logic signed [LW-1:0] packed_lane0, packed_lane1, packed_lane2, packed_lane3;
    logic signed [LW-1:0] rest_lane0, rest_lane1, rest_lane2, rest_lane3;
    int cycle_count = 0;

    lane_perm_scoreboard perm_sb = new();

    active_lane_consolidation_permute_core #(
        .LANE_WIDTH(LW)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .first_lane0 (first_lane0),
        .first_lane1 (first_lane1),
        .first_lane2 (first_lane2),
        .first_lane3 (first_lane3),
        .second_lane0(second_lane0),
        .second_lane1(second_lane1),
        .second_lane2(second_lane2),
        .second_lane3(second_lane3),
        .first_mask  (first_mask),
        .second_mask (second_mask),
        .done        (done),
        .packed_lane0(packed_lane0),
        .packed_lane1(packed_lane1),
        .packed_lane2(packed_lane2),
        .packed_lane3(packed_lane3),
        .rest_lane0  (rest_lane0),
        .rest_lane1  (rest_lane1),
        .rest_lane2  (rest_lane2),
        .rest_lane3  (rest_lane3)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_active_lane_consolidation_permute_core: FAIL");
            $finish;
        end
    end

    // Every result strobe is taken at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            perm_sb.check_result('{packed_v: {packed_lane3, packed_lane2,
                                              packed_lane1, packed_lane0},
                                   rest_v:   {rest_lane3, rest_lane2,
                                              rest_lane1, rest_lane0}});
    end

    // Lane values lean toward the extremes now and then.
    function automatic logic [LW-1:0] rand_lane();
        case ($urandom_range(15))
            0:       return '0;
            1:       return {1'b1, {(LW-1){1'b0}}};
            2:       return {1'b0, {(LW-1){1'b1}}};
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_pair_t rand_item();
        vec_pair_t it;
        for (int i = 0; i < LANES; i++) begin
            it.first_v[i]  = rand_lane();
            it.second_v[i] = rand_lane();
        end
        it.first_m  = lane_mask_t'($urandom_range(15));
        it.second_m = lane_mask_t'($urandom_range(15));
        return it;
    endfunction

    task automatic drive_ports(vec_pair_t it, logic go);
        start        <= go;
        first_lane0  <= it.first_v[0];
        first_lane1  <= it.first_v[1];
        first_lane2  <= it.first_v[2];
        first_lane3  <= it.first_v[3];
        second_lane0 <= it.second_v[0];
        second_lane1 <= it.second_v[1];
        second_lane2 <= it.second_v[2];
        second_lane3 <= it.second_v[3];
        first_mask   <= it.first_m;
        second_mask  <= it.second_m;
    endtask

    // Offer one item after a random idle stretch; junk is driven while idle.
    task automatic send_item(vec_pair_t it, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            drive_ports(rand_item(), 1'b0);
            @(posedge clk);
        end
        drive_ports(it, 1'b1);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        perm_sb.note_item(it);
    endtask

    task automatic go_quiet();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender off until every owed result has arrived.
    task automatic drain_results();
        while (perm_sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        vec_pair_t it;
        int idle_pct;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: mask corners with distinct, sign-carrying lane values.
        foreach (DIR_MASKS[k]) begin
            for (int i = 0; i < LANES; i++) begin
                it.first_v[i]  = 32'h8100_0000 + (k << 8) + i;
                it.second_v[i] = 32'h0200_0000 + (k << 8) + 16 + i;
            end
            it.first_m  = DIR_MASKS[k][7:4];
            it.second_m = DIR_MASKS[k][3:0];
            send_item(it, 0);
        end

        // Lanes at the value extremes.
        it.first_v  = {LANES{32'h8000_0000}};
        it.second_v = {LANES{32'h7FFF_FFFF}};
        it.first_m  = 4'h5;
        it.second_m = 4'hA;
        send_item(it, 0);
        it.first_v  = {LANES{32'h7FFF_FFFF}};
        it.second_v = {LANES{32'h8000_0000}};
        it.first_m  = 4'hF;
        it.second_m = 4'h0;
        send_item(it, 0);
        it.first_v  = '1;
        it.second_v = '0;
        it.first_m  = 4'h6;
        it.second_m = 4'h3;
        send_item(it, 0);
        it.first_v  = '0;
        it.second_v = '1;
        it.first_m  = 4'h0;
        it.second_m = 4'hC;
        send_item(it, 0);
        go_quiet();
        drain_results();

        // Random part in three phases of sender idling.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 14 : (phase == 1) ? 73 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(rand_item(), idle_pct);
                if ($urandom_range(39) == 0) begin
                    go_quiet();
                    drain_results();
                end
            end
            go_quiet();
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (perm_sb.errors == 0 && perm_sb.pending() == 0)
            $display("tb_active_lane_consolidation_permute_core: PASS");
        else
            $display("tb_active_lane_consolidation_permute_core: FAIL");
        $finish;
    end

endmodule
